// File: hw/rtl/spa_pkg.sv
// Package with the shared types, codes and the parity helper function of the SPI register access master.
package spa_pkg;

	localparam int CfgWidth     = 12;
	localparam int CfgIdxWidth  = 3;
	localparam int CounterBits  = 12;
	localparam int WordWidth    = 14;
	localparam int FrameWidth   = 16;
	localparam int InDataWidth  = 32;
	localparam int OutDataWidth = 24;

	localparam logic [CfgWidth-1:0] SetupTicksRst  = 12'd20;
	localparam logic [CfgWidth-1:0] HighTicksRst   = 12'd40;
	localparam logic [CfgWidth-1:0] SampleTicksRst = 12'd10;
	localparam logic [CfgWidth-1:0] LowTicksRst    = 12'd30;
	localparam logic [CfgWidth-1:0] HoldTicksRst   = 12'd100;
	localparam logic [CfgWidth-1:0] GapTicksRst    = 12'd150;

	localparam logic [FrameWidth-1:0] ReadDummyFrame = 16'hC000;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_SPARE = 2'd3
	} func_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_SETUP  = 3'd0,
		REG_HIGH   = 3'd1,
		REG_SAMPLE = 3'd2,
		REG_LOW    = 3'd3,
		REG_HOLD   = 3'd4,
		REG_GAP    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SETUP  = 3'd1,
		PH_HIGH   = 3'd2,
		PH_SAMPLE = 3'd3,
		PH_LOW    = 3'd4,
		PH_HOLD   = 3'd5,
		PH_GAP    = 3'd6
	} phase_t;

	typedef struct packed {
		logic [CfgWidth-1:0] setup_ticks;
		logic [CfgWidth-1:0] high_ticks;
		logic [CfgWidth-1:0] sample_ticks;
		logic [CfgWidth-1:0] low_ticks;
		logic [CfgWidth-1:0] hold_ticks;
		logic [CfgWidth-1:0] gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           func;
		logic [WordWidth-1:0] addr;
		logic [WordWidth-1:0] wdata;
		logic                 miso;
	} tick_in_t;

	typedef struct packed {
		logic                 nss;
		logic                 sck;
		logic                 mosi;
		logic                 busy_res;
		logic                 done_res;
		logic [WordWidth-1:0] rdata;
		logic                 error_flag;
		logic                 parity_error;
	} tick_out_t;

	// Even parity over bits 14..0 placed in bit 15.
	function automatic logic [FrameWidth-1:0] with_parity(input logic [FrameWidth-2:0] v);
		return {^v, v};
	endfunction

endpackage

// File: hw/rtl/spa_fsm.sv
// Phase sequencer: frame timing, bit shifting and read capture for one tick per item.
module spa_fsm import spa_pkg::*; #(
	parameter int COUNTER_BITS = CounterBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  tick_in_t  tick_in,
	input  cfg_t      cfg,
	output tick_out_t tick_out
);

	localparam int LenWidth = (COUNTER_BITS > CfgWidth) ? COUNTER_BITS : CfgWidth;
	localparam logic [LenWidth-1:0] MaxCount = LenWidth'((1 << COUNTER_BITS) - 1);

	phase_t                  phase_q, phase_d;
	logic [COUNTER_BITS-1:0] tick_count_q, tick_count_d, tick_inc;
	logic [3:0]              bit_index_q, bit_index_d;
	logic                    second_frame_q, second_frame_d;
	logic                    is_read_q, is_read_d;
	logic [FrameWidth-1:0]   tx_frame_q, tx_frame_d;
	logic [FrameWidth-1:0]   rx_frame_q, rx_frame_d;
	logic [WordWidth-1:0]    pending_data_q, pending_data_d;
	logic [FrameWidth-1:0]   read_result_q, read_result_d;
	logic                    mosi_q, mosi_d;
	logic                    done;
	logic [CfgWidth-1:0]     len_raw;
	logic [LenWidth-1:0]     len_wide, len_eff;
	logic                    start_rd;

	always_comb begin
		case (phase_q)
			PH_SETUP:  len_raw = cfg.setup_ticks;
			PH_HIGH:   len_raw = cfg.high_ticks;
			PH_SAMPLE: len_raw = cfg.sample_ticks;
			PH_LOW:    len_raw = cfg.low_ticks;
			PH_HOLD:   len_raw = cfg.hold_ticks;
			default:   len_raw = cfg.gap_ticks;
		endcase
		len_wide = LenWidth'(len_raw);
		if (len_wide == '0) begin
			len_eff = LenWidth'(1);
		end else if (len_wide > MaxCount) begin
			len_eff = MaxCount;
		end else begin
			len_eff = len_wide;
		end
	end

	assign tick_inc = tick_count_q + COUNTER_BITS'(1);
	assign start_rd = (tick_in.func == FUNC_READ);

	always_comb begin
		phase_d        = phase_q;
		tick_count_d   = tick_count_q;
		bit_index_d    = bit_index_q;
		second_frame_d = second_frame_q;
		is_read_d      = is_read_q;
		tx_frame_d     = tx_frame_q;
		rx_frame_d     = rx_frame_q;
		pending_data_d = pending_data_q;
		read_result_d  = read_result_q;
		mosi_d         = mosi_q;
		done           = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (tick_in.func == FUNC_WRITE || tick_in.func == FUNC_READ) begin
				is_read_d      = start_rd;
				second_frame_d = 1'b0;
				if (!start_rd) begin
					pending_data_d = tick_in.wdata;
				end
				tx_frame_d   = with_parity({start_rd, tick_in.addr});
				bit_index_d  = 4'd15;
				rx_frame_d   = '0;
				phase_d      = PH_SETUP;
				tick_count_d = '0;
			end
		end else if (LenWidth'(tick_inc) >= len_eff) begin
			tick_count_d = '0;
			case (phase_q)
				PH_SETUP: begin
					phase_d = PH_HIGH;
					mosi_d  = tx_frame_q[bit_index_q];
				end
				PH_HIGH: begin
					phase_d = PH_SAMPLE;
				end
				PH_SAMPLE: begin
					rx_frame_d[bit_index_q] = tick_in.miso;
					phase_d                 = PH_LOW;
				end
				PH_LOW: begin
					if (bit_index_q == 4'd0) begin
						phase_d = PH_HOLD;
					end else begin
						bit_index_d = bit_index_q - 4'd1;
						phase_d     = PH_HIGH;
						mosi_d      = tx_frame_q[bit_index_q - 4'd1];
					end
				end
				PH_HOLD: begin
					if (second_frame_q && is_read_q) begin
						read_result_d = rx_frame_q;
						phase_d       = PH_IDLE;
						done          = 1'b1;
					end else begin
						phase_d = PH_GAP;
					end
				end
				PH_GAP: begin
					if (!second_frame_q) begin
						second_frame_d = 1'b1;
						tx_frame_d     = is_read_q ? ReadDummyFrame
						                           : with_parity({1'b0, pending_data_q});
						bit_index_d    = 4'd15;
						rx_frame_d     = '0;
						phase_d        = PH_SETUP;
					end else begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end else begin
			tick_count_d = tick_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			tick_count_q   <= '0;
			bit_index_q    <= 4'd15;
			second_frame_q <= 1'b0;
			is_read_q      <= 1'b0;
			tx_frame_q     <= '0;
			rx_frame_q     <= '0;
			pending_data_q <= '0;
			read_result_q  <= '0;
			mosi_q         <= 1'b1;
		end else if (step) begin
			phase_q        <= phase_d;
			tick_count_q   <= tick_count_d;
			bit_index_q    <= bit_index_d;
			second_frame_q <= second_frame_d;
			is_read_q      <= is_read_d;
			tx_frame_q     <= tx_frame_d;
			rx_frame_q     <= rx_frame_d;
			pending_data_q <= pending_data_d;
			read_result_q  <= read_result_d;
			mosi_q         <= mosi_d;
		end
	end

	always_comb begin
		tick_out.nss          = !(phase_d == PH_SETUP || phase_d == PH_HIGH ||
		                          phase_d == PH_SAMPLE || phase_d == PH_LOW);
		tick_out.sck          = (phase_d == PH_HIGH);
		tick_out.mosi         = mosi_d;
		tick_out.busy_res     = (phase_d != PH_IDLE);
		tick_out.done_res     = done;
		tick_out.rdata        = read_result_d[WordWidth-1:0];
		tick_out.error_flag   = read_result_d[WordWidth];
		tick_out.parity_error = ^read_result_d;
	end

endmodule

// File: hw/rtl/spi_parity_register_access_master_core.sv
// Top level of the SPI register access master: configuration registers, handshake and result register.
//
//  Channel  Direction  Handshake          Payload
//  s        in         s_tvalid/s_tready  tuser: func; tdata: addr, wdata, miso
//  m        out        m_tvalid/m_tready  tdata: nss, sck, mosi, busy, done, rdata, err, parity
//  cfg      in         cfg_we             cfg_idx selects the register, cfg_wdata the value
//
// Every accepted item is one tick of the serial timing and yields one result item in the next cycle.
// One item is taken per clock unless the result side stalls; the result register is the only
// stage, so s_tready is high whenever the result register is empty or being taken in the same cycle.
// Reset puts the sequencer idle with the timing registers at their defaults.
// A stall on the result side holds the result and the sequencer state until it is taken.
module spi_parity_register_access_master_core import spa_pkg::*; #(
	parameter int COUNTER_BITS = CounterBits
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [InDataWidth-1:0]  s_tdata,  // addr[13:0], wdata[27:14], miso[28], zero fill
	input  logic [1:0]              s_tuser,  // func[1:0]
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OutDataWidth-1:0] m_tdata,  // nss, sck, mosi, busy_res, done_res, rdata[18:5],
	                                          // error_flag[19], parity_error[20], zero fill
	input  logic                    cfg_we,
	input  logic [CfgIdxWidth-1:0]  cfg_idx,
	input  logic [CfgWidth-1:0]     cfg_wdata
);

	cfg_t      cfg_q;
	tick_in_t  tick_in;
	tick_out_t tick_out;
	tick_out_t res_q;
	logic      res_valid_q;
	logic      step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_ticks  <= SetupTicksRst;
			cfg_q.high_ticks   <= HighTicksRst;
			cfg_q.sample_ticks <= SampleTicksRst;
			cfg_q.low_ticks    <= LowTicksRst;
			cfg_q.hold_ticks   <= HoldTicksRst;
			cfg_q.gap_ticks    <= GapTicksRst;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SETUP:  cfg_q.setup_ticks  <= cfg_wdata;
				REG_HIGH:   cfg_q.high_ticks   <= cfg_wdata;
				REG_SAMPLE: cfg_q.sample_ticks <= cfg_wdata;
				REG_LOW:    cfg_q.low_ticks    <= cfg_wdata;
				REG_HOLD:   cfg_q.hold_ticks   <= cfg_wdata;
				REG_GAP:    cfg_q.gap_ticks    <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	assign tick_in.func  = s_tuser;
	assign tick_in.addr  = s_tdata[WordWidth-1:0];
	assign tick_in.wdata = s_tdata[2*WordWidth-1:WordWidth];
	assign tick_in.miso  = s_tdata[2*WordWidth];

	assign s_tready = !res_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	spa_fsm #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.tick_in  (tick_in),
		.cfg      (cfg_q),
		.tick_out (tick_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s_tready) begin
			res_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= tick_out;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {3'b000, res_q.parity_error, res_q.error_flag, res_q.rdata,
	                   res_q.done_res, res_q.busy_res, res_q.mosi, res_q.sck, res_q.nss};

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.done_res |-> !res_q.busy_res)
		else $error("done pulse while still busy");

	a_sck_needs_nss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.sck |-> !res_q.nss)
		else $error("serial clock high with chip select released");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item produced no result");
`endif

endmodule

// File: tb/spa_tick_checker.sv
// Checker that predicts every result item of the SPI register access master and compares it.
module spa_tick_checker import spa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [InDataWidth-1:0]  s_tdata,  // addr[13:0], wdata[27:14], miso[28], zero fill
	input  logic [1:0]              s_tuser,  // func[1:0]
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [OutDataWidth-1:0] m_tdata,  // nss, sck, mosi, busy_res, done_res, rdata[18:5],
	                                          // error_flag[19], parity_error[20], zero fill
	input  logic                    cfg_we,
	input  logic [CfgIdxWidth-1:0]  cfg_idx,
	input  logic [CfgWidth-1:0]     cfg_wdata,
	output int                      failures
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t                   timing;
	phase_t                 seq_phase;
	logic [CounterBits-1:0] tick_cnt;
	logic [3:0]             bit_pos;
	logic                   second;
	logic                   rd;
	logic [FrameWidth-1:0]  tx;
	logic [FrameWidth-1:0]  rx;
	logic [FrameWidth-1:0]  rd_word;
	logic [WordWidth-1:0]   wr_pending;
	logic                   mosi_q;
	tick_out_t              expected_ticks [$];

	function automatic logic [FrameWidth-1:0] framed(logic [FrameWidth-2:0] body);
		return {^body, body};
	endfunction

	function automatic void open_frame();
		bit_pos = 4'd15;
		rx = '0;
		seq_phase = PH_SETUP;
		tick_cnt = '0;
	endfunction

	function automatic tick_out_t sequencer_step(tick_in_t t);
		tick_out_t r;
		logic [CfgWidth-1:0] span;
		logic done;
		done = 1'b0;
		if (seq_phase == PH_IDLE) begin
			if (t.func == FUNC_WRITE || t.func == FUNC_READ) begin
				rd = (t.func == FUNC_READ);
				second = 1'b0;
				if (!rd)
					wr_pending = t.wdata;
				tx = framed({rd, t.addr});
				open_frame();
			end
		end else begin
			case (seq_phase)
				PH_SETUP:  span = timing.setup_ticks;
				PH_HIGH:   span = timing.high_ticks;
				PH_SAMPLE: span = timing.sample_ticks;
				PH_LOW:    span = timing.low_ticks;
				PH_HOLD:   span = timing.hold_ticks;
				default:   span = timing.gap_ticks;
			endcase
			if (span == '0)
				span = CfgWidth'(1);
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt >= span) begin
				tick_cnt = '0;
				case (seq_phase)
					PH_SETUP: begin
						seq_phase = PH_HIGH;
						mosi_q = tx[bit_pos];
					end
					PH_HIGH: seq_phase = PH_SAMPLE;
					PH_SAMPLE: begin
						rx[bit_pos] = t.miso;
						seq_phase = PH_LOW;
					end
					PH_LOW: begin
						if (bit_pos == 4'd0) begin
							seq_phase = PH_HOLD;
						end else begin
							bit_pos = bit_pos - 1'b1;
							seq_phase = PH_HIGH;
							mosi_q = tx[bit_pos];
						end
					end
					PH_HOLD: begin
						if (second && rd) begin
							rd_word = rx;
							seq_phase = PH_IDLE;
							done = 1'b1;
						end else begin
							seq_phase = PH_GAP;
						end
					end
					PH_GAP: begin
						if (!second) begin
							second = 1'b1;
							tx = rd ? ReadDummyFrame : framed({1'b0, wr_pending});
							open_frame();
						end else begin
							seq_phase = PH_IDLE;
							done = 1'b1;
						end
					end
					default: seq_phase = PH_IDLE;
				endcase
			end
		end
		r.nss = !(seq_phase inside {PH_SETUP, PH_HIGH, PH_SAMPLE, PH_LOW});
		r.sck = (seq_phase == PH_HIGH);
		r.mosi = mosi_q;
		r.busy_res = (seq_phase != PH_IDLE);
		r.done_res = done;
		r.rdata = rd_word[WordWidth-1:0];
		r.error_flag = rd_word[14];
		r.parity_error = rd_word[15] != ^rd_word[14:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		tick_in_t  t;
		tick_out_t want;
		tick_out_t got;
		logic [7:0] bad;
		if (!arst_n) begin
			timing = {SetupTicksRst, HighTicksRst, SampleTicksRst, LowTicksRst, HoldTicksRst,
				GapTicksRst};
			seq_phase = PH_IDLE;
			tick_cnt = '0;
			bit_pos = 4'd15;
			second = 1'b0;
			rd = 1'b0;
			tx = '0;
			rx = '0;
			rd_word = '0;
			wr_pending = '0;
			mosi_q = 1'b1;
			expected_ticks.delete();
			failures = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.nss = m_tdata[0];
				got.sck = m_tdata[1];
				got.mosi = m_tdata[2];
				got.busy_res = m_tdata[3];
				got.done_res = m_tdata[4];
				got.rdata = m_tdata[18:5];
				got.error_flag = m_tdata[19];
				got.parity_error = m_tdata[20];
				if (expected_ticks.size() == 0) begin
					if (failures < 10)
						$display("%0t: result item with nothing expected: %h", $realtime, m_tdata);
					failures = failures + 1;
				end else begin
					want = expected_ticks.pop_front();
					bad = {want.nss !== got.nss, want.sck !== got.sck, want.mosi !== got.mosi,
						want.busy_res !== got.busy_res, want.done_res !== got.done_res,
						want.rdata !== got.rdata, want.error_flag !== got.error_flag,
						want.parity_error !== got.parity_error};
					if (|bad) begin
						if (failures < 10) begin
							$display("%0t: mismatch, expected nss %b sck %b mosi %b busy %b done %b",
								$realtime, want.nss, want.sck, want.mosi, want.busy_res,
								want.done_res, " rdata %h err %b par %b", want.rdata,
								want.error_flag, want.parity_error);
							$display("%0t:           actual nss %b sck %b mosi %b busy %b done %b",
								$realtime, got.nss, got.sck, got.mosi, got.busy_res,
								got.done_res, " rdata %h err %b par %b", got.rdata,
								got.error_flag, got.parity_error);
						end
						failures = failures + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				t.func = s_tuser;
				t.addr = s_tdata[13:0];
				t.wdata = s_tdata[27:14];
				t.miso = s_tdata[28];
				expected_ticks.push_back(sequencer_step(t));
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_SETUP:  timing.setup_ticks = cfg_wdata;
					REG_HIGH:   timing.high_ticks = cfg_wdata;
					REG_SAMPLE: timing.sample_ticks = cfg_wdata;
					REG_LOW:    timing.low_ticks = cfg_wdata;
					REG_HOLD:   timing.hold_ticks = cfg_wdata;
					REG_GAP:    timing.gap_ticks = cfg_wdata;
					default:    ;
				endcase
			end
		end
	end

endmodule

// File: tb/spi_parity_register_access_master_core_tb.sv
// Testbench top of the SPI register access master: clock, reset, stimulus, back-pressure and verdict.
module spi_parity_register_access_master_core_tb import spa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit     = 20000;
	localparam int HoldOffCycles = 300;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [InDataWidth-1:0]  s_tdata;  // addr[13:0], wdata[27:14], miso[28], zero fill
	logic [1:0]              s_tuser;  // func[1:0]
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OutDataWidth-1:0] m_tdata;  // nss, sck, mosi, busy_res, done_res, rdata[18:5],
	                                   // error_flag[19], parity_error[20], zero fill
	logic                    cfg_we;
	logic [CfgIdxWidth-1:0]  cfg_idx;
	logic [CfgWidth-1:0]     cfg_wdata;
	int                      mismatches;

	int   sent;
	int   received;
	int   idle_cycles;
	int   hold_requests;
	int   holds_served;
	int   writes;
	int   reads;
	int   settings;
	bit   quiet;
	cfg_t timing;

	spi_parity_register_access_master_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	spa_tick_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.failures (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sent <= sent + 1;
		if (m_tvalid && m_tready)
			received <= received + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("spi_parity_register_access_master_core verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			if (holds_served != hold_requests) begin
				holds_served = holds_served + 1;
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 18);
			end
			@(posedge clk);
		end
	end

	function automatic int eff(logic [CfgWidth-1:0] v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	// Ticks from the start of an access to its done tick under the current timing.
	function automatic int span_of(logic is_rd);
		int frame;
		frame = eff(timing.setup_ticks) + 16 * (eff(timing.high_ticks) +
			eff(timing.sample_ticks) + eff(timing.low_ticks));
		return 2 * frame + 2 * eff(timing.hold_ticks) + eff(timing.gap_ticks) * (is_rd ? 1 : 2);
	endfunction

	task automatic put_tick(func_t f, logic [WordWidth-1:0] a, logic [WordWidth-1:0] w, logic m);
		while (!quiet && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {{(InDataWidth - 29){1'b0}}, m, w, a};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (received != sent);
	endtask

	task automatic load_timing(cfg_t c);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SETUP;
		cfg_wdata <= c.setup_ticks;
		@(posedge clk);
		cfg_idx <= REG_HIGH;
		cfg_wdata <= c.high_ticks;
		@(posedge clk);
		cfg_idx <= REG_SAMPLE;
		cfg_wdata <= c.sample_ticks;
		@(posedge clk);
		cfg_idx <= REG_LOW;
		cfg_wdata <= c.low_ticks;
		@(posedge clk);
		cfg_idx <= REG_HOLD;
		cfg_wdata <= c.hold_ticks;
		@(posedge clk);
		cfg_idx <= REG_GAP;
		cfg_wdata <= c.gap_ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		timing = c;
		settings++;
	endtask

	// The done tick always carries a random code, so a start there must be ignored.
	task automatic run_access(func_t f, logic [WordWidth-1:0] a, logic [WordWidth-1:0] w,
		int mode, int noise_pct);
		int span;
		logic m;
		span = span_of(f == FUNC_READ);
		if (f == FUNC_READ)
			reads++;
		else
			writes++;
		put_tick(f, a, w, 1'($urandom_range(1)));
		for (int k = 1; k <= span; k++) begin
			m = (mode == 0) ? 1'($urandom_range(1)) : (mode == 1);
			if (k == span || $urandom_range(99) < noise_pct)
				put_tick(func_t'($urandom_range(3)), 14'($urandom_range(16383)),
					14'($urandom_range(16383)), m);
			else
				put_tick(FUNC_TICK, 14'($urandom_range(16383)), 14'($urandom_range(16383)), m);
		end
		repeat ($urandom_range(3))
			put_tick($urandom_range(1) ? FUNC_SPARE : FUNC_TICK, 14'($urandom_range(16383)),
				14'($urandom_range(16383)), 1'($urandom_range(1)));
	endtask

	initial begin
		cfg_t c;
		int mark;
		int n;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= FUNC_TICK;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_SETUP;
		cfg_wdata <= '0;
		sent = 0;
		received = 0;
		idle_cycles = 0;
		hold_requests = 0;
		holds_served = 0;
		writes = 0;
		reads = 0;
		settings = 1;
		quiet = 1'b0;
		timing = {SetupTicksRst, HighTicksRst, SampleTicksRst, LowTicksRst, HoldTicksRst,
			GapTicksRst};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A read under the reset timing is cut short in its second bit and then finished
		// with every phase one tick long.
		reads++;
		put_tick(FUNC_READ, 14'h1555, 14'h2AAA, 1'b1);
		repeat (129)
			put_tick(func_t'($urandom_range(3)), 14'($urandom_range(16383)),
				14'($urandom_range(16383)), 1'($urandom_range(1)));
		drain();
		c = '0;
		load_timing(c);
		repeat (110)
			put_tick(FUNC_TICK, 14'($urandom_range(16383)), 14'($urandom_range(16383)),
				1'($urandom_range(1)));
		run_access(FUNC_READ, 14'h0000, 14'h3FFF, 1, 0);
		put_tick(FUNC_SPARE, 14'h3FFF, 14'h3FFF, 1'b1);

		for (int p = 0; p < 5; p++) begin
			drain();
			if (p == 0) begin
				c = {12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1};
			end else begin
				c.setup_ticks = 12'($urandom_range(12));
				c.high_ticks = 12'($urandom_range(3));
				c.sample_ticks = 12'($urandom_range(3));
				c.low_ticks = 12'($urandom_range(3));
				c.hold_ticks = 12'($urandom_range(12));
				c.gap_ticks = 12'($urandom_range(12));
			end
			load_timing(c);
			quiet = (p == 3);
			mark = sent;
			n = 0;
			while (sent - mark < 100) begin
				if (p == 1 && n == 0)
					hold_requests++;
				if (p == 2 && n == 1)
					drain();
				run_access($urandom_range(1) ? FUNC_READ : FUNC_WRITE, 14'($urandom_range(16383)),
					14'($urandom_range(16383)),
					($urandom_range(9) < 8) ? 0 : int'($urandom_range(2, 1)), 10);
				n++;
			end
		end
		quiet = 1'b0;

		drain();
		repeat (4) @(posedge clk);
		$display("Run covered %0d items: %0d writes and %0d reads under %0d timing settings,",
			sent, writes, reads, settings);
		$display("from the reset timing and all-zero registers to random short phases, with a long result hold-off.");
		if (mismatches == 0 && received == sent)
			$display("spi_parity_register_access_master_core verification clean");
		else
			$display("spi_parity_register_access_master_core verification failed");
		$finish;
	end

endmodule
